// ===== hdl/ps2dec_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2dec_pkg
// Shared types, scancode constants and AZERTY translation tables for the
// PS/2 set-1 scancode decoder.
// ----------------------------------------------------------------------------
package ps2dec_pkg;

	localparam int LINE_LEN_DEF = 256;

	typedef logic [7:0] byte_t;
	typedef logic [6:0] key_t;
	typedef logic [2:0] dir_t;

	localparam byte_t BREAK_MASK = 8'h80;
	localparam byte_t KEY_MASK   = 8'h7F;
	localparam byte_t LED_CMD    = 8'hED;
	localparam logic [2:0] LED_CAPS = 3'h2;
	localparam logic [2:0] LED_NUM  = 3'h1;
	localparam logic [2:0] LED_OFF  = 3'h0;

	localparam key_t KEY_LSHIFT = 7'd42;
	localparam key_t KEY_RSHIFT = 7'd54;
	localparam key_t KEY_CAPS   = 7'd58;
	localparam key_t KEY_NUM    = 7'd69;
	localparam key_t KEY_ENTER  = 7'd28;
	localparam key_t KEY_BKSP   = 7'd14;
	localparam key_t KEY_DEL    = 7'd83;
	localparam key_t KEY_LEFT   = 7'd75;
	localparam key_t KEY_RIGHT  = 7'd77;
	localparam key_t KEY_UP     = 7'd72;
	localparam key_t KEY_DOWN   = 7'd80;

	localparam dir_t DIR_NONE  = 3'd0;
	localparam dir_t DIR_LEFT  = 3'd1;
	localparam dir_t DIR_RIGHT = 3'd2;
	localparam dir_t DIR_UP    = 3'd3;
	localparam dir_t DIR_DOWN  = 3'd4;

	localparam byte_t CHAR_SPACE = 8'h20;

	function automatic dir_t arrow_code(key_t key);
		dir_t d;
		case (key)
			KEY_LEFT:  d = DIR_LEFT;
			KEY_RIGHT: d = DIR_RIGHT;
			KEY_UP:    d = DIR_UP;
			KEY_DOWN:  d = DIR_DOWN;
			default:   d = DIR_NONE;
		endcase
		return d;
	endfunction

	// Unshifted AZERTY layer; keys with no character give zero.
	function automatic byte_t plain_map(key_t key);
		byte_t c;
		case (key)
			7'd1:  c = 8'h1B;
			7'd2:  c = "&";
			7'd3:  c = "e";
			7'd4:  c = 8'h22;
			7'd5:  c = 8'h27;
			7'd6:  c = "(";
			7'd7:  c = "-";
			7'd8:  c = "e";
			7'd9:  c = "_";
			7'd10: c = "c";
			7'd11: c = "a";
			7'd12: c = ")";
			7'd13: c = "=";
			7'd14: c = 8'h08;
			7'd15: c = 8'h09;
			7'd16: c = "a";
			7'd17: c = "z";
			7'd18: c = "e";
			7'd19: c = "r";
			7'd20: c = "t";
			7'd21: c = "y";
			7'd22: c = "u";
			7'd23: c = "i";
			7'd24: c = "o";
			7'd25: c = "p";
			7'd26: c = "^";
			7'd27: c = "$";
			7'd28: c = 8'h0A;
			7'd30: c = "q";
			7'd31: c = "s";
			7'd32: c = "d";
			7'd33: c = "f";
			7'd34: c = "g";
			7'd35: c = "h";
			7'd36: c = "j";
			7'd37: c = "k";
			7'd38: c = "l";
			7'd39: c = "m";
			7'd40: c = "u";
			7'd43: c = "*";
			7'd44: c = "w";
			7'd45: c = "x";
			7'd46: c = "c";
			7'd47: c = "v";
			7'd48: c = "b";
			7'd49: c = "n";
			7'd50: c = ",";
			7'd51: c = ";";
			7'd52: c = ":";
			7'd53: c = "!";
			7'd55: c = "*";
			7'd57: c = CHAR_SPACE;
			7'd74: c = "-";
			7'd78: c = "+";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Shifted AZERTY layer.
	function automatic byte_t shifted_map(key_t key);
		byte_t c;
		case (key)
			7'd1:  c = 8'h1B;
			7'd2:  c = "1";
			7'd3:  c = "2";
			7'd4:  c = "3";
			7'd5:  c = "4";
			7'd6:  c = "5";
			7'd7:  c = "6";
			7'd8:  c = "7";
			7'd9:  c = "8";
			7'd10: c = "9";
			7'd11: c = "0";
			7'd12: c = 8'h27;
			7'd13: c = "+";
			7'd14: c = 8'h08;
			7'd15: c = 8'h09;
			7'd16: c = "A";
			7'd17: c = "Z";
			7'd18: c = "E";
			7'd19: c = "R";
			7'd20: c = "T";
			7'd21: c = "Y";
			7'd22: c = "U";
			7'd23: c = "I";
			7'd24: c = "O";
			7'd25: c = "P";
			7'd26: c = "^";
			7'd27: c = "$";
			7'd28: c = 8'h0A;
			7'd30: c = "Q";
			7'd31: c = "S";
			7'd32: c = "D";
			7'd33: c = "F";
			7'd34: c = "G";
			7'd35: c = "H";
			7'd36: c = "J";
			7'd37: c = "K";
			7'd38: c = "L";
			7'd39: c = "M";
			7'd40: c = "U";
			7'd43: c = "*";
			7'd44: c = "W";
			7'd45: c = "X";
			7'd46: c = "C";
			7'd47: c = "V";
			7'd48: c = "B";
			7'd49: c = "N";
			7'd50: c = "?";
			7'd51: c = ".";
			7'd52: c = "/";
			7'd53: c = "!";
			7'd55: c = "*";
			7'd57: c = CHAR_SPACE;
			7'd74: c = "-";
			7'd78: c = "+";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// ===== hdl/ps2dec_if.sv =====
// ----------------------------------------------------------------------------
// ps2dec interfaces
// Valid/ready channels for scancode input and decoded result output.
// ----------------------------------------------------------------------------
interface ps2dec_scan_if;
	logic                 valid;
	logic                 ready;
	ps2dec_pkg::byte_t    scancode;

	modport source (output valid, output scancode, input ready);
	modport sink   (input valid, input scancode, output ready);
endinterface

interface ps2dec_result_if;
	logic                 valid;
	logic                 ready;
	ps2dec_pkg::byte_t    key_char;
	logic                 char_valid;
	logic                 key_down;
	logic                 key_up;
	ps2dec_pkg::dir_t     arrow_held;
	ps2dec_pkg::dir_t     arrow_let_go;
	logic                 led_write;
	logic [2:0]           led_byte;
	logic                 line_end;
	ps2dec_pkg::byte_t    cursor;
	logic                 ignored;

	modport source (output valid, output key_char, output char_valid, output key_down,
		output key_up, output arrow_held, output arrow_let_go, output led_write,
		output led_byte, output line_end, output cursor, output ignored, input ready);
	modport sink   (input valid, input key_char, input char_valid, input key_down,
		input key_up, input arrow_held, input arrow_let_go, input led_write,
		input led_byte, input line_end, input cursor, input ignored, output ready);
endinterface

// ===== hdl/ps2_scancode_to_char_decoder_core.sv =====
// ----------------------------------------------------------------------------
// ps2_scancode_to_char_decoder_core
// PS/2 set-1 scancode to AZERTY character decoder with lock, arrow and
// line cursor tracking.
// ----------------------------------------------------------------------------
// Usage:
// Raw set-1 scancode bytes arrive one per transaction on the scan channel.
// Every accepted scancode yields exactly one result transaction on the
// result channel, carrying the decoder state after that byte plus the
// per-byte flags (new character, LED command request, end of line, ignored).
// The accepted byte is held in an input register; the decode stage then
// decodes it against the tracked state and, when the result register is
// free or being drained, updates that state and loads the result register.
// Throughput is one transaction per cycle while the receiver does not
// stall, set by the single decode stage between the input and result
// registers; state written by one byte is seen by the byte right behind it.
// When the receiver stalls, the result register holds its transaction, the
// input register holds the next byte, and scan.ready falls only when both
// are full. An asynchronous low on arst_n clears both valid bits and all
// tracked state (shift, locks, flags, arrows, cursor, gui mode).
// gui_mode is written through cfg_we/cfg_wdata; the user must write it only
// while the block is idle, which the block itself does not enforce; while it
// is set every byte is reported as ignored and state is unchanged.
// ----------------------------------------------------------------------------
module ps2_scancode_to_char_decoder_core #(
	parameter int LINE_LEN = ps2dec_pkg::LINE_LEN_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	ps2dec_scan_if.sink            scan,
	ps2dec_result_if.source        result,
	input  logic                   cfg_we,
	input  logic                   cfg_wdata
);

	// The cursor saturates at the end of the line, but never beyond 8 bits.
	localparam int CURSOR_MAX_I = ((LINE_LEN - 1) < 255) ? (LINE_LEN - 1) : 255;
	localparam ps2dec_pkg::byte_t CURSOR_MAX = 8'(CURSOR_MAX_I);

	// Configuration and tracked state.
	logic                gui_mode_q;
	logic                shift_q;
	logic                caps_q;
	logic                num_q;
	ps2dec_pkg::byte_t   last_char_q;
	logic                press_q;
	logic                release_q;
	ps2dec_pkg::dir_t    arrow_press_q;
	ps2dec_pkg::dir_t    arrow_release_q;
	ps2dec_pkg::byte_t   line_pos_q;

	// Input register (stage 1) and result register (stage 2).
	logic                valid_s1;
	ps2dec_pkg::byte_t   scancode_s1;
	logic                valid_s2;
	logic                char_valid_s2;
	logic                led_write_s2;
	logic [2:0]          led_byte_s2;
	logic                line_end_s2;
	logic                ignored_s2;

	// The decode stage moves forward whenever the result register is free
	// or being drained this cycle.
	logic advance;
	assign advance    = !valid_s2 || result.ready;
	assign scan.ready = !valid_s1 || advance;

	// Next-state decode for the byte sitting in the input register.
	logic                shift_d, caps_d, num_d, press_d, release_d;
	ps2dec_pkg::byte_t   last_char_d, line_pos_d;
	ps2dec_pkg::dir_t    arrow_press_d, arrow_release_d;
	logic                char_valid_d, led_write_d, line_end_d, ignored_d;
	logic [2:0]          led_byte_d;
	ps2dec_pkg::key_t    key;
	ps2dec_pkg::dir_t    dir;
	logic                is_break;

	assign key      = scancode_s1[6:0];
	assign is_break = |(scancode_s1 & ps2dec_pkg::BREAK_MASK);
	assign dir      = ps2dec_pkg::arrow_code(key);

	always_comb begin
		shift_d         = shift_q;
		caps_d          = caps_q;
		num_d           = num_q;
		press_d         = press_q;
		release_d       = release_q;
		last_char_d     = last_char_q;
		line_pos_d      = line_pos_q;
		arrow_press_d   = arrow_press_q;
		arrow_release_d = arrow_release_q;
		char_valid_d    = 1'b0;
		led_write_d     = 1'b0;
		led_byte_d      = ps2dec_pkg::LED_OFF;
		line_end_d      = 1'b0;
		ignored_d       = 1'b0;

		if (gui_mode_q) begin
			ignored_d = 1'b1;
		end else if (is_break) begin
			// Release: shift keys clear the shift state and arrows record which direction let go.
			if (key inside {ps2dec_pkg::KEY_LSHIFT, ps2dec_pkg::KEY_RSHIFT}) begin
				shift_d = 1'b0;
			end else if (dir != ps2dec_pkg::DIR_NONE) begin
				arrow_release_d = dir;
			end
			press_d   = 1'b0;
			release_d = 1'b1;
		end else if (key == ps2dec_pkg::KEY_ENTER) begin
			line_end_d = 1'b1;
			line_pos_d = '0;
		end else if (key == ps2dec_pkg::KEY_DEL) begin
			if (line_pos_q < CURSOR_MAX) begin
				line_pos_d = line_pos_q + 8'd1;
			end
			last_char_d = ps2dec_pkg::CHAR_SPACE;
		end else if (key == ps2dec_pkg::KEY_BKSP) begin
			if (line_pos_q != '0) begin
				line_pos_d = line_pos_q - 8'd1;
			end
			last_char_d = ps2dec_pkg::CHAR_SPACE;
		end else if (key inside {ps2dec_pkg::KEY_LSHIFT, ps2dec_pkg::KEY_RSHIFT}) begin
			shift_d = 1'b1;
		end else if (key == ps2dec_pkg::KEY_CAPS) begin
			caps_d      = !caps_q;
			led_write_d = 1'b1;
			led_byte_d  = caps_d ? ps2dec_pkg::LED_CAPS : ps2dec_pkg::LED_OFF;
		end else if (key == ps2dec_pkg::KEY_NUM) begin
			num_d       = !num_q;
			led_write_d = 1'b1;
			led_byte_d  = num_d ? ps2dec_pkg::LED_NUM : ps2dec_pkg::LED_OFF;
		end else if (dir != ps2dec_pkg::DIR_NONE) begin
			arrow_press_d = dir;
		end else begin
			// Character key: shift and caps lock cancel each other.
			last_char_d = (shift_q ^ caps_q) ? ps2dec_pkg::shifted_map(key)
			                                 : ps2dec_pkg::plain_map(key);
			if (line_pos_q < CURSOR_MAX) begin
				line_pos_d = line_pos_q + 8'd1;
			end
			char_valid_d = 1'b1;
			press_d      = 1'b1;
			release_d    = 1'b0;
		end
	end

	// Control registers and tracked state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gui_mode_q      <= 1'b0;
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			shift_q         <= 1'b0;
			caps_q          <= 1'b0;
			num_q           <= 1'b0;
			last_char_q     <= '0;
			press_q         <= 1'b0;
			release_q       <= 1'b0;
			arrow_press_q   <= ps2dec_pkg::DIR_NONE;
			arrow_release_q <= ps2dec_pkg::DIR_NONE;
			line_pos_q      <= '0;
		end else begin
			if (cfg_we) begin
				gui_mode_q <= cfg_wdata;
			end
			if (scan.ready) begin
				valid_s1 <= scan.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (advance && valid_s1) begin
				shift_q         <= shift_d;
				caps_q          <= caps_d;
				num_q           <= num_d;
				last_char_q     <= last_char_d;
				press_q         <= press_d;
				release_q       <= release_d;
				arrow_press_q   <= arrow_press_d;
				arrow_release_q <= arrow_release_d;
				line_pos_q      <= line_pos_d;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (scan.ready && scan.valid) begin
			scancode_s1 <= scan.scancode;
		end
		if (advance && valid_s1) begin
			char_valid_s2 <= char_valid_d;
			led_write_s2  <= led_write_d;
			led_byte_s2   <= led_byte_d;
			line_end_s2   <= line_end_d;
			ignored_s2    <= ignored_d;
		end
	end

	// The state registers are updated in the same edge as the result
	// register, so they already hold the post-item state for the result.
	assign result.valid        = valid_s2;
	assign result.key_char     = last_char_q;
	assign result.char_valid   = char_valid_s2;
	assign result.key_down     = press_q;
	assign result.key_up       = release_q;
	assign result.arrow_held   = arrow_press_q;
	assign result.arrow_let_go = arrow_release_q;
	assign result.led_write    = led_write_s2;
	assign result.led_byte     = led_byte_s2;
	assign result.line_end     = line_end_s2;
	assign result.cursor       = line_pos_q;
	assign result.ignored      = ignored_s2;

endmodule

// ===== hdl/ps2dec_chk.sv =====
// ----------------------------------------------------------------------------
// ps2dec_chk
// Port-level checks for the scancode decoder, bound to the decoder core.
// ----------------------------------------------------------------------------
module ps2dec_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        char_valid,
	input logic        key_down,
	input logic        key_up,
	input logic [2:0]  arrow_held,
	input logic        led_write,
	input logic [2:0]  led_byte,
	input logic        line_end,
	input logic [7:0]  cursor,
	input logic        ignored
);

	// A dropped byte never reports any per-byte event.
	a_ignored_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ignored |-> !char_valid && !led_write && !line_end)
		else $error("ignored result carries an event");

	// The LED mask only means something alongside a command request.
	a_led_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !led_write |-> led_byte == 3'd0)
		else $error("LED mask set without LED command");

	// Enter always puts the cursor back at the start of the line.
	a_enter_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_end |-> cursor == 8'd0)
		else $error("line end with nonzero cursor");

	// A new character is a press, and clears the released flag.
	a_char_press: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> key_down && !key_up)
		else $error("character without press flag");

	// Arrow direction stays within its encoding.
	a_arrow_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> arrow_held <= 3'd4)
		else $error("arrow direction out of range");

endmodule

bind ps2_scancode_to_char_decoder_core ps2dec_chk u_ps2dec_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result.valid),
	.char_valid (result.char_valid),
	.key_down   (result.key_down),
	.key_up     (result.key_up),
	.arrow_held (result.arrow_held),
	.led_write  (result.led_write),
	.led_byte   (result.led_byte),
	.line_end   (result.line_end),
	.cursor     (result.cursor),
	.ignored    (result.ignored)
);
